>>> hw/rtl/modular_arithmetic_unit_top_defines.svh
// Assertion macros for the modular arithmetic unit.
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define MAU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mau_pkg.sv
// Types and constants shared by the modular arithmetic unit.
package mau_pkg;

    localparam int DATA_W = 16;

    localparam logic [DATA_W-1:0] MODULUS_RESET = 16'd17;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_mau_in;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              not_invertible;
        logic              a_less;
        logic              equal;
    } t_mau_out;

endpackage

>>> hw/rtl/mau_core.sv
// Sequencer and shared compare-subtract datapath of the modular arithmetic unit.
module mau_core #(
    parameter int WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start_valid,
    output logic              o_start_ready,
    input  mau_pkg::t_mau_in  i_item,
    input  logic [WIDTH-1:0]  i_modulus,
    output logic              o_done,
    input  logic              i_take,
    output mau_pkg::t_mau_out o_res
);
    import mau_pkg::*;

    localparam int KW = $clog2(WIDTH);
    localparam int TW = WIDTH + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ALIGN = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SWAP  = 4'd3;
    localparam logic [3:0] S_OP    = 4'd4;
    localparam logic [3:0] S_EUC   = 4'd5;
    localparam logic [3:0] S_MDBL  = 4'd6;
    localparam logic [3:0] S_MADD  = 4'd7;
    localparam logic [3:0] S_FIX   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [1:0] PH_RED_A = 2'd0;
    localparam logic [1:0] PH_RED_B = 2'd1;
    localparam logic [1:0] PH_EUC   = 2'd2;

    logic [3:0]              r_state, n_state;
    logic [1:0]              r_phase, n_phase;
    logic [1:0]              r_op, n_op;
    logic [WIDTH-1:0]        r_n, n_n;
    logic [WIDTH-1:0]        r_braw, n_braw;
    logic [WIDTH-1:0]        r_ra, n_ra;
    logic [WIDTH-1:0]        r_rb, n_rb;
    logic [WIDTH-1:0]        r_r0, n_r0;
    logic [WIDTH-1:0]        r_r1, n_r1;
    logic [WIDTH-1:0]        r_d, n_d;
    logic [KW-1:0]           r_k, n_k;
    logic [KW-1:0]           r_cnt, n_cnt;
    logic [WIDTH-1:0]        r_acc, n_acc;
    logic [WIDTH-1:0]        r_x, n_x;
    logic signed [TW-1:0]    r_t0, n_t0;
    logic signed [TW-1:0]    r_t1, n_t1;
    logic signed [TW-1:0]    r_p, n_p;
    logic                    r_err, n_err;
    logic                    r_less, n_less;
    logic                    r_eq, n_eq;

    // shared unit: pre-adder followed by a compare-subtract
    logic [WIDTH-1:0]        w_pa, w_pb;
    logic [WIDTH:0]          w_y;
    logic [WIDTH:0]          w_x;
    logic [WIDTH+1:0]        w_diff;
    logic                    w_ge;
    logic [WIDTH-1:0]        w_rem;
    logic [WIDTH-1:0]        w_nmod;
    logic signed [TW-1:0]    w_nt;
    logic signed [TW-1:0]    w_inv_full;

    // pick the operands of the shared unit by step
    always_comb begin
        w_pa = '0;
        w_pb = '0;
        w_y  = '0;
        case (r_state)
            S_ALIGN: begin
                w_pa = r_r0;
                w_y  = {r_d, 1'b0};
            end
            S_DIV: begin
                w_pa = r_r0;
                w_y  = {1'b0, r_d};
            end
            S_OP: begin
                w_pa = r_ra;
                if (r_op == OP_ADD) begin
                    w_pb = r_rb;
                    w_y  = {1'b0, r_n};
                end else begin
                    w_y  = {1'b0, r_rb};
                end
            end
            S_MDBL: begin
                w_pa = r_acc;
                w_pb = r_acc;
                w_y  = {1'b0, r_n};
            end
            S_MADD: begin
                w_pa = r_acc;
                w_pb = r_x[WIDTH-1] ? r_ra : '0;
                w_y  = {1'b0, r_n};
            end
            S_FIX: begin
                w_pa = r_acc;
                w_pb = r_n;
            end
            default: begin
                w_pa = '0;
            end
        endcase
    end

    assign w_x    = {1'b0, w_pa} + {1'b0, w_pb};
    assign w_diff = {1'b0, w_x} - {1'b0, w_y};
    assign w_ge   = ~w_diff[WIDTH+1];
    assign w_rem  = w_ge ? w_diff[WIDTH-1:0] : r_r0;

    // a zero modulus behaves as modulus one
    assign w_nmod     = (i_modulus == '0) ? WIDTH'(1) : i_modulus;
    assign w_nt       = {2'b00, r_n};
    assign w_inv_full = r_t0[TW-1] ? (r_t0 + w_nt) : r_t0;

    // sequence the reductions, the operation and the inverse search
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_op    = r_op;
        n_n     = r_n;
        n_braw  = r_braw;
        n_ra    = r_ra;
        n_rb    = r_rb;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_d     = r_d;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_x     = r_x;
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_p     = r_p;
        n_err   = r_err;
        n_less  = r_less;
        n_eq    = r_eq;
        case (r_state)
            S_IDLE: begin
                if (i_start_valid) begin
                    n_op    = i_item.opcode;
                    n_n     = w_nmod;
                    n_r0    = WIDTH'(i_item.operand_a);
                    n_braw  = WIDTH'(i_item.operand_b);
                    n_d     = w_nmod;
                    n_k     = '0;
                    n_p     = '0;
                    n_phase = PH_RED_A;
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                // shift the divisor up while it still fits under the dividend
                if (w_ge) begin
                    n_d = {r_d[WIDTH-2:0], 1'b0};
                    n_k = r_k + KW'(1);
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_r0 = w_rem;
                n_p  = {r_p[TW-2:0], 1'b0} + (w_ge ? r_t1 : TW'(0));
                n_d  = {1'b0, r_d[WIDTH-1:1]};
                if (r_k != '0) begin
                    n_k = r_k - KW'(1);
                end else begin
                    case (r_phase)
                        PH_RED_A: begin
                            n_ra    = w_rem;
                            n_r0    = r_braw;
                            n_d     = r_n;
                            n_k     = '0;
                            n_phase = PH_RED_B;
                            n_state = S_ALIGN;
                        end
                        PH_RED_B: begin
                            n_rb    = w_rem;
                            n_state = S_OP;
                        end
                        default: begin
                            n_state = S_SWAP;
                        end
                    endcase
                end
            end
            S_SWAP: begin
                n_r0    = r_r1;
                n_r1    = r_r0;
                n_t0    = r_t1;
                n_t1    = r_t0 - r_p;
                n_state = S_EUC;
            end
            S_OP: begin
                n_less = (r_ra < r_rb);
                n_eq   = (r_ra == r_rb);
                n_err  = 1'b0;
                case (r_op)
                    OP_ADD: begin
                        n_acc   = w_ge ? w_diff[WIDTH-1:0] : w_x[WIDTH-1:0];
                        n_state = S_DONE;
                    end
                    OP_SUB: begin
                        // a borrow wraps; adding the modulus brings it back in range
                        n_acc   = w_diff[WIDTH-1:0];
                        n_state = w_ge ? S_DONE : S_FIX;
                    end
                    OP_MUL: begin
                        n_acc   = '0;
                        n_x     = r_rb;
                        n_cnt   = KW'(WIDTH - 1);
                        n_state = S_MDBL;
                    end
                    default: begin
                        n_r0    = r_n;
                        n_r1    = r_rb;
                        n_t0    = '0;
                        n_t1    = TW'(1);
                        n_state = S_EUC;
                    end
                endcase
            end
            S_EUC: begin
                if (r_r1 == '0) begin
                    if (r_r0 == WIDTH'(1)) begin
                        n_x     = w_inv_full[WIDTH-1:0];
                        n_acc   = '0;
                        n_cnt   = KW'(WIDTH - 1);
                        n_state = S_MDBL;
                    end else begin
                        n_acc   = '0;
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_d     = r_r1;
                    n_k     = '0;
                    n_p     = '0;
                    n_phase = PH_EUC;
                    n_state = S_ALIGN;
                end
            end
            S_MDBL: begin
                n_acc   = w_ge ? w_diff[WIDTH-1:0] : w_x[WIDTH-1:0];
                n_state = S_MADD;
            end
            S_MADD: begin
                n_acc = w_ge ? w_diff[WIDTH-1:0] : w_x[WIDTH-1:0];
                n_x   = {r_x[WIDTH-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt   = r_cnt - KW'(1);
                    n_state = S_MDBL;
                end
            end
            S_FIX: begin
                n_acc   = w_x[WIDTH-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_RED_A;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // advance the datapath registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_n    <= n_n;
        r_braw <= n_braw;
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_r0   <= n_r0;
        r_r1   <= n_r1;
        r_d    <= n_d;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_x    <= n_x;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_p    <= n_p;
        r_err  <= n_err;
        r_less <= n_less;
        r_eq   <= n_eq;
    end

    assign o_start_ready        = (r_state == S_IDLE);
    assign o_done               = (r_state == S_DONE);
    assign o_res.result         = DATA_W'(r_acc);
    assign o_res.not_invertible = r_err;
    assign o_res.a_less         = r_less;
    assign o_res.equal          = r_eq;

endmodule

>>> hw/rtl/modular_arithmetic_unit_top.sv
// Top level of the modular arithmetic unit: register port, core and output register.
//
// Each item reduces both operands below the modulus N and returns their sum,
// difference, product or quotient mod N, with less-than and equal flags of the
// reduced operands; a divide whose divisor has no inverse returns zero with
// not_invertible set. One item is in work at a time and o_in_ready is low from
// acceptance until the result enters the output register. The reductions, the
// operation and the remainder steps of the divide run through one shared
// compare-subtract unit, one step per cycle, so the item time depends on the data.
// Reducing an operand first doubles N k times, where k counts the doublings of N
// that stay at or below it, then takes one quotient bit per step. After the
// operation step, a subtract that borrows adds a fix step and a multiply adds a
// doubling and an adding step for each multiplier bit. A divide runs extended
// Euclid, an align, divide and swap pass for each remainder step plus one final
// check, then the multiply when the inverse exists; without an inverse it ends
// after the search. The result waits in the done state until the output register
// is empty or being drained and then enters it; the core is then ready for the
// next item. The modulus register is read at byte address 0 and written at any
// address; it resets to 17 and a zero modulus acts as modulus one.
`include "modular_arithmetic_unit_top_defines.svh"

module modular_arithmetic_unit_top #(
    parameter int WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mau_pkg::t_mau_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mau_pkg::t_mau_out o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import mau_pkg::*;

    logic [DATA_W-1:0] r_modulus;
    logic              r_out_valid;
    t_mau_out          r_out_data;
    logic              w_done;
    logic              w_take;
    t_mau_out          w_res;

    // write the modulus on the access phase of a register transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (psel && penable && pwrite) begin
            r_modulus <= pwdata[DATA_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'b00) ? {{(32-DATA_W){1'b0}}, r_modulus} : '0;

    mau_core #(
        .WIDTH(WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_valid (i_in_valid),
        .o_start_ready (o_in_ready),
        .i_item        (i_in_data),
        .i_modulus     (WIDTH'(r_modulus)),
        .o_done        (w_done),
        .i_take        (w_take),
        .o_res         (w_res)
    );

    // load the output register when it is empty or being drained
    assign w_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_take) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // check result consistency and the busy handshake
    `MAU_ASSERT_SAME(a_err_zero, o_out_valid && o_out_data.not_invertible, o_out_data.result == '0, "not_invertible result is not zero")
    `MAU_ASSERT_SAME(a_flags_excl, o_out_valid && o_out_data.equal, !o_out_data.a_less, "equal and a_less both set")
    `MAU_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready right after a transfer")

endmodule
